// ----- hw/rtl/piwb_pkg.sv -----
// shared types, register codes and constants of the particle integrator
package piwb_pkg;

  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned ADDR_W    = 5;

  localparam logic [REG_IDX_W-1:0] REG_X_LOW  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_Y_LOW  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_X_HIGH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_HIGH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TSTEP  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN = 3'd5;

  localparam logic [31:0] RST_X_LOW  = 32'd0;
  localparam logic [31:0] RST_Y_LOW  = 32'd0;
  localparam logic [31:0] RST_X_HIGH = 32'd65536;
  localparam logic [31:0] RST_Y_HIGH = 32'd65536;
  localparam logic [23:0] RST_TSTEP  = 24'd655;
  localparam logic [15:0] RST_MARGIN = 16'd66;

  localparam int unsigned ROOT_W  = 16;
  localparam int unsigned ALPHA_W = 17;
  localparam logic [ALPHA_W-1:0] Q_ONE = 17'd65536;

  // number of register stages inside the motion and speed units
  localparam int unsigned UNIT_DEPTH = 6;

  typedef struct packed {
    logic signed [31:0] x_low_bound;
    logic signed [31:0] y_low_bound;
    logic signed [31:0] x_high_bound;
    logic signed [31:0] y_high_bound;
    logic [23:0]        time_step;
    logic [15:0]        bounce_margin;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } mot_res_t;

  typedef struct packed {
    logic              big;
    logic [ROOT_W-1:0] root;
  } alpha_res_t;

endpackage

// ----- hw/rtl/particle_integrate_with_boundaries_unit.sv -----
// top level: register port, stream handshake and output register of the particle integrator
// an accepted item passes through the unit stages and then the output register to reach m_axis
// throughput: one item per cycle; seven register stages (multiply, round, clamp,
//   edge tests, two boundary update steps, output) and a square root at four bits a stage
// back pressure stalls every stage at once, so nothing is lost or repeated
// reset: registers take their defaults and the pipeline empties; no clearing pass
module particle_integrate_with_boundaries_unit
  import piwb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input items
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [127:0]       s_axis_tdata,  // pos_x, pos_y, vel_x, vel_y
  input  logic               s_axis_tlast,  // last_in
  // result items
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y, speed_alpha, speed_complement, zero pad
  output logic [167:0]       m_axis_tdata,
  output logic               m_axis_tlast   // last_out
);

  // ---------------------------------------------------------------- registers
  cfg_t                 cfg_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_low_bound   <= RST_X_LOW;
      cfg_q.y_low_bound   <= RST_Y_LOW;
      cfg_q.x_high_bound  <= RST_X_HIGH;
      cfg_q.y_high_bound  <= RST_Y_HIGH;
      cfg_q.time_step     <= RST_TSTEP;
      cfg_q.bounce_margin <= RST_MARGIN;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_X_LOW:  cfg_q.x_low_bound   <= pwdata;
        REG_Y_LOW:  cfg_q.y_low_bound   <= pwdata;
        REG_X_HIGH: cfg_q.x_high_bound  <= pwdata;
        REG_Y_HIGH: cfg_q.y_high_bound  <= pwdata;
        REG_TSTEP:  cfg_q.time_step     <= pwdata[23:0];
        REG_MARGIN: cfg_q.bounce_margin <= pwdata[15:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_X_LOW:  prdata = cfg_q.x_low_bound;
      REG_Y_LOW:  prdata = cfg_q.y_low_bound;
      REG_X_HIGH: prdata = cfg_q.x_high_bound;
      REG_Y_HIGH: prdata = cfg_q.y_high_bound;
      REG_TSTEP:  prdata = {8'd0, cfg_q.time_step};
      REG_MARGIN: prdata = {16'd0, cfg_q.bounce_margin};
      default:    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- pipeline control
  // the whole pipe moves when the output register is empty or being drained
  logic                  adv;
  logic [UNIT_DEPTH-1:0] valid_q;
  logic [UNIT_DEPTH-1:0] last_q;
  logic                  out_valid_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q     <= {valid_q[UNIT_DEPTH-2:0], s_axis_tvalid};
      out_valid_q <= valid_q[UNIT_DEPTH-1];
    end
  end

  // ---------------------------------------------------------------- datapath units
  mot_res_t   mot_res;
  alpha_res_t alpha_res;

  piwb_motion u_motion (
    .clk_i   (clk_i),
    .en_i    (adv),
    .cfg_i   (cfg_q),
    .pos_x_i (s_axis_tdata[31:0]),
    .pos_y_i (s_axis_tdata[63:32]),
    .vel_x_i (s_axis_tdata[95:64]),
    .vel_y_i (s_axis_tdata[127:96]),
    .res_o   (mot_res)
  );

  piwb_alpha u_alpha (
    .clk_i   (clk_i),
    .en_i    (adv),
    .vel_x_i (s_axis_tdata[95:64]),
    .vel_y_i (s_axis_tdata[127:96]),
    .res_o   (alpha_res)
  );

  // speed of one or more clips to one
  logic [ALPHA_W-1:0] alpha_d;
  logic [ALPHA_W-1:0] comp_d;
  assign alpha_d = alpha_res.big ? Q_ONE : {1'b0, alpha_res.root};
  assign comp_d  = Q_ONE - alpha_d;

  // ---------------------------------------------------------------- output register
  logic [167:0] out_data_q;
  logic         out_last_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      last_q     <= {last_q[UNIT_DEPTH-2:0], s_axis_tlast};
      out_last_q <= last_q[UNIT_DEPTH-1];
      out_data_q <= {6'd0, comp_d, alpha_d, mot_res.vel_y, mot_res.vel_x,
                     mot_res.pos_y, mot_res.pos_x};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- hw/rtl/piwb_motion.sv -----
// six-stage position update with boundary wrap and reflection
module piwb_motion
  import piwb_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  cfg_t               cfg_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  output mot_res_t           res_o
);

  localparam int unsigned SUM_W = 42;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed({{(SUM_W-32){1'b0}}, 32'h7fff_ffff})) begin
      r = 32'sh7fff_ffff;
    end else if (v < $signed({{(SUM_W-32){1'b1}}, 32'h8000_0000})) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [31:0] v);
    return $signed({{(SUM_W-32){v[31]}}, v});
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == 32'sh8000_0000) begin
      r = 32'sh7fff_ffff;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  logic signed [SUM_W-1:0] m_ext;
  assign m_ext = $signed({{(SUM_W-16){1'b0}}, cfg_i.bounce_margin});

  // stage 1: velocity times time step
  logic signed [56:0] prod_x_q, prod_y_q;
  logic signed [31:0] px1_q, py1_q, vx1_q, vy1_q;
  // stage 2: rounded displacement
  logic signed [40:0] dx_q, dy_q;
  logic signed [31:0] px2_q, py2_q, vx2_q, vy2_q;
  // stage 3: clamped new position
  logic signed [31:0] nx_q, ny_q, px3_q, vx3_q, vy3_q;
  // stage 4: edge tests and candidates
  logic signed [31:0] x0_q, cxl_q, y4_q, vx4_q, vy4_q;
  logic signed [32:0] e4_q;
  logic               hy4_q, lx4_q, ly4_q;
  // stage 5: top crossing and left wrap applied
  logic signed [31:0] x2_q, y5_q, vx5_q, vy5_q;
  logic signed [32:0] e5_q;
  logic               ly5_q;
  // stage 6: result
  mot_res_t           res_q;

  logic signed [56:0] rnd_x, rnd_y;
  assign rnd_x = prod_x_q + 57'sd32768;
  assign rnd_y = prod_y_q + 57'sd32768;

  logic signed [SUM_W-1:0] sum_x, sum_y;
  assign sum_x = ext(px2_q) + $signed({dx_q[40], dx_q});
  assign sum_y = ext(py2_q) + $signed({dy_q[40], dy_q});

  logic signed [SUM_W-1:0] e_w;
  logic                    hx, hy, lx, ly;
  logic signed [31:0]      cxh, cxl, cyh, cyl, y4_d, vy4_d;
  always_comb begin
    e_w = ext(nx_q) - ext(px3_q);
    hx  = nx_q > cfg_i.x_high_bound;
    hy  = ny_q > cfg_i.y_high_bound;
    lx  = nx_q < cfg_i.x_low_bound;
    ly  = ny_q < cfg_i.y_low_bound;
    cxh = sat32(ext(cfg_i.x_low_bound) + m_ext + ext(nx_q) - ext(cfg_i.x_high_bound));
    cxl = sat32(ext(cfg_i.x_high_bound) + m_ext + ext(nx_q) - ext(cfg_i.x_low_bound));
    cyh = sat32(ext(cfg_i.y_high_bound) + ext(cfg_i.y_high_bound) - m_ext - ext(ny_q));
    cyl = sat32(ext(cfg_i.y_low_bound) + ext(cfg_i.y_low_bound) + m_ext - ext(ny_q));
    // bottom test comes first, so it wins when both fire
    if (ly) begin
      y4_d = cyl;
    end else if (hy) begin
      y4_d = cyh;
    end else begin
      y4_d = ny_q;
    end
    if (hy && ly) begin
      vy4_d = neg_sat(neg_sat(vy3_q));
    end else if (hy || ly) begin
      vy4_d = neg_sat(vy3_q);
    end else begin
      vy4_d = vy3_q;
    end
  end

  logic signed [SUM_W-1:0] e4_ext, e5_ext;
  assign e4_ext = $signed({{(SUM_W-33){e4_q[32]}}, e4_q});
  assign e5_ext = $signed({{(SUM_W-33){e5_q[32]}}, e5_q});

  logic signed [31:0] x1, x2_d, x3;
  always_comb begin
    x1   = hy4_q ? sat32(ext(x0_q) + e4_ext) : x0_q;
    x2_d = lx4_q ? cxl_q : x1;
    x3   = ly5_q ? sat32(ext(x2_q) + e5_ext) : x2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= $signed(vel_x_i) * $signed({1'b0, cfg_i.time_step});
      prod_y_q <= $signed(vel_y_i) * $signed({1'b0, cfg_i.time_step});
      px1_q <= pos_x_i;
      py1_q <= pos_y_i;
      vx1_q <= vel_x_i;
      vy1_q <= vel_y_i;

      dx_q  <= rnd_x[56:16];
      dy_q  <= rnd_y[56:16];
      px2_q <= px1_q;
      py2_q <= py1_q;
      vx2_q <= vx1_q;
      vy2_q <= vy1_q;

      nx_q  <= sat32(sum_x);
      ny_q  <= sat32(sum_y);
      px3_q <= px2_q;
      vx3_q <= vx2_q;
      vy3_q <= vy2_q;

      x0_q  <= hx ? cxh : nx_q;
      cxl_q <= cxl;
      y4_q  <= y4_d;
      vx4_q <= lx ? neg_sat(vx3_q) : vx3_q;
      vy4_q <= vy4_d;
      e4_q  <= e_w[32:0];
      hy4_q <= hy;
      lx4_q <= lx;
      ly4_q <= ly;

      x2_q  <= x2_d;
      y5_q  <= y4_q;
      vx5_q <= vx4_q;
      vy5_q <= vy4_q;
      e5_q  <= e4_q;
      ly5_q <= ly4_q;

      res_q.pos_x <= x3;
      res_q.pos_y <= y5_q;
      res_q.vel_x <= vx5_q;
      res_q.vel_y <= vy5_q;
    end
  end

  assign res_o = res_q;

endmodule

// ----- hw/rtl/piwb_alpha.sv -----
// six-stage speed magnitude: squares, sum and a pipelined integer square root
module piwb_alpha
  import piwb_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  output alpha_res_t         res_o
);

  localparam int unsigned REM_W     = ROOT_W + 2;
  localparam int unsigned BITS_STEP = 4;
  localparam int unsigned SQ_STAGES = ROOT_W / BITS_STEP;

  typedef struct packed {
    logic [2*ROOT_W-1:0] n;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
    logic                big;
  } sq_t;

  // four restoring square root steps, two radicand bits each
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t              r;
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    r = s;
    for (int i = 0; i < BITS_STEP; i++) begin
      cur   = {r.rem, r.n[2*ROOT_W-1 -: 2]};
      trial = {2'b00, r.root, 2'b01};
      r.n   = {r.n[2*ROOT_W-3:0], 2'b00};
      if (cur >= trial) begin
        r.rem  = REM_W'(cur - trial);
        r.root = {r.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.rem  = cur[REM_W-1:0];
        r.root = {r.root[ROOT_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // stage 1: squares of the low bits, valid when both magnitudes are below one
  logic [31:0] sqx_q, sqy_q;
  logic        big1_q;
  logic signed [33:0] sqx_w, sqy_w;
  logic               big_x, big_y;
  always_comb begin
    sqx_w = $signed(vel_x_i[16:0]) * $signed(vel_x_i[16:0]);
    sqy_w = $signed(vel_y_i[16:0]) * $signed(vel_y_i[16:0]);
    big_x = (vel_x_i >= 32'sd65536) || (vel_x_i <= -32'sd65536);
    big_y = (vel_y_i >= 32'sd65536) || (vel_y_i <= -32'sd65536);
  end

  // stage 2: sum of squares
  sq_t         sum_q;
  logic [32:0] sum_w;
  assign sum_w = {1'b0, sqx_q} + {1'b0, sqy_q};

  sq_t stage_q [SQ_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q  <= sqx_w[31:0];
      sqy_q  <= sqy_w[31:0];
      big1_q <= big_x || big_y;

      sum_q.n    <= sum_w[31:0];
      sum_q.rem  <= '0;
      sum_q.root <= '0;
      sum_q.big  <= big1_q || sum_w[32];

      stage_q[0] <= sqrt_step(sum_q);
      for (int k = 1; k < SQ_STAGES; k++) begin
        stage_q[k] <= sqrt_step(stage_q[k-1]);
      end
    end
  end

  assign res_o.big  = stage_q[SQ_STAGES-1].big;
  assign res_o.root = stage_q[SQ_STAGES-1].root;

endmodule

// ----- hw/rtl/piwb_checker.sv -----
// port-level checks of the particle integrator, bound to the top level
module piwb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [167:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // alpha and its complement add up to one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ({1'b0, m_axis_tdata[144:128]} + {1'b0, m_axis_tdata[161:145]}) == 18'd65536)
    else $error("alpha and complement do not sum to one");

  // alpha never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[144:128] <= 17'd65536)
    else $error("alpha above one");

  // an empty output register never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // reset empties the pipeline
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result shown after reset");

endmodule

bind particle_integrate_with_boundaries_unit piwb_checker u_piwb_checker (.*);
